// ===== design/tmt_pkg.sv =====
`default_nettype none

package tmt_pkg;

    // Window and field sizes
    localparam int WINDOW_SIZE = 16;
    localparam int DATA_W      = 32;
    localparam int TIME_W      = 64;

    // Cell tag and rank widths, median rank
    localparam int IDX_W       = (WINDOW_SIZE > 1) ? $clog2(WINDOW_SIZE) : 1;
    localparam int RANK_W      = $clog2(WINDOW_SIZE + 1);
    localparam int MEDIAN_RANK = WINDOW_SIZE / 2;

    localparam logic [DATA_W-1:0] GUESS_RESET = 32'd1000000;
    localparam logic [DATA_W-1:0] DATA_MAX    = {DATA_W{1'b1}};

    // Commands that the sequencer hands to every cell
    typedef struct packed {
        logic fill;    // load every cell with the guess
        logic shift;   // push a new interval in, drop the oldest
        logic start;   // copy own value into the rotating slot, clear rank
        logic rotate;  // count against the visiting value, pass it on
    } cell_ctrl_t;

endpackage

`default_nettype wire

// ===== design/tmt_cell.sv =====
`default_nettype none

module tmt_cell
    import tmt_pkg::*;
(
    input  wire logic              clk,
    input  wire cell_ctrl_t        ctrl,
    input  wire logic [IDX_W-1:0]  cell_index,
    input  wire logic [DATA_W-1:0] fill_value,
    input  wire logic [DATA_W-1:0] shift_in,
    input  wire logic [DATA_W-1:0] rot_in_value,
    input  wire logic [IDX_W-1:0]  rot_in_tag,
    output logic [DATA_W-1:0]      stat_value,
    output logic [DATA_W-1:0]      rot_value,
    output logic [IDX_W-1:0]       rot_tag,
    output logic                   is_median
);

    logic [DATA_W-1:0] stat_reg;
    logic [DATA_W-1:0] rot_value_reg;
    logic [IDX_W-1:0]  rot_tag_reg;
    logic [RANK_W-1:0] rank_reg;
    logic              below;

    // Visiting value sorts before ours: smaller, or equal with a lower slot
    assign below = (rot_value_reg < stat_reg) ||
                   ((rot_value_reg == stat_reg) && (rot_tag_reg < cell_index));

    // Hold the stored interval
    always_ff @(posedge clk)
    begin
        if (ctrl.fill)
        begin
            stat_reg <= fill_value;
        end
        else if (ctrl.shift)
        begin
            stat_reg <= shift_in;
        end
    end

    // Rotate values around the ring and count those that rank below
    always_ff @(posedge clk)
    begin
        if (ctrl.start)
        begin
            rot_value_reg <= stat_reg;
            rot_tag_reg   <= cell_index;
            rank_reg      <= '0;
        end
        else if (ctrl.rotate)
        begin
            rot_value_reg <= rot_in_value;
            rot_tag_reg   <= rot_in_tag;
            rank_reg      <= rank_reg + RANK_W'(below);
        end
    end

    assign stat_value = stat_reg;
    assign rot_value  = rot_value_reg;
    assign rot_tag    = rot_tag_reg;
    assign is_median  = (rank_reg == RANK_W'(MEDIAN_RANK));

endmodule

`default_nettype wire

// ===== design/trigger_interval_median_tracker_unit.sv =====
`default_nettype none

// Channel    Handshake              Word
// --------   --------------------   ---------------------------------
// input      in_valid / in_stall    trigger_time[63:0]
// output     out_valid / out_stall  median_interval[31:0], median_valid
// config     config_we              config_data[31:0]
//
// For each timestamp the sequencer takes the word and shifts the new
// interval into the cell row, arms the ranking, rotates the values once
// around the ring while each cell counts, then picks the median.
// The first timestamp after reset only fills the row with the guess and goes straight to the pick step.
// Reset clears the sequencer, the previous-timestamp flag and the output
// valid flag, and loads the default guess.
// A stalled result holds in the output register; the next word may be taken
// meanwhile and waits at the pick step until the register is free.

module trigger_interval_median_tracker_unit
    import tmt_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              config_we,
    input  wire logic [DATA_W-1:0] config_data,
    input  wire logic              in_valid,
    output logic                   in_stall,
    input  wire logic [TIME_W-1:0] trigger_time,
    output logic                   out_valid,
    input  wire logic              out_stall,
    output logic [DATA_W-1:0]      median_interval,
    output logic                   median_valid
);

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_START = 2'd1;
    localparam logic [1:0] S_ROT   = 2'd2;
    localparam logic [1:0] S_DONE  = 2'd3;

    logic [1:0]        state_reg, state_next;
    logic [IDX_W-1:0]  count_reg, count_next;
    logic              have_prev_reg;
    logic              first_reg;
    logic [TIME_W-1:0] prev_time_reg;
    logic [DATA_W-1:0] guess_reg;
    logic              out_valid_reg;
    logic [DATA_W-1:0] out_median_reg;
    logic              out_flag_reg;

    logic              in_accept;
    logic              out_free;
    logic [TIME_W-1:0] time_diff;
    logic [DATA_W-1:0] interval;
    logic [DATA_W-1:0] picked;
    cell_ctrl_t        ctrl;

    logic [DATA_W-1:0] stat_value [WINDOW_SIZE];
    logic [DATA_W-1:0] rot_value  [WINDOW_SIZE];
    logic [IDX_W-1:0]  rot_tag    [WINDOW_SIZE];
    logic              is_median  [WINDOW_SIZE];

    assign in_stall  = (state_reg != S_IDLE);
    assign in_accept = in_valid && !in_stall;
    assign out_free  = !out_valid_reg || !out_stall;

    // Clamp backward time to zero, saturate a huge gap
    assign time_diff = trigger_time - prev_time_reg;
    always_comb
    begin
        if (trigger_time < prev_time_reg)
        begin
            interval = '0;
        end
        else if (time_diff[TIME_W-1:DATA_W] != '0)
        begin
            interval = DATA_MAX;
        end
        else
        begin
            interval = time_diff[DATA_W-1:0];
        end
    end

    // Sequence the cell row
    always_comb
    begin
        state_next  = state_reg;
        count_next  = count_reg;
        ctrl        = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_accept)
                begin
                    if (have_prev_reg)
                    begin
                        ctrl.shift = 1'b1;
                        state_next = S_START;
                    end
                    else
                    begin
                        ctrl.fill  = 1'b1;
                        state_next = S_DONE;
                    end
                end
            end
            S_START:
            begin
                ctrl.start = 1'b1;
                count_next = '0;
                state_next = S_ROT;
            end
            S_ROT:
            begin
                ctrl.rotate = 1'b1;
                count_next  = count_reg + 1'b1;
                if (count_reg == IDX_W'(WINDOW_SIZE - 1))
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            have_prev_reg <= 1'b0;
            first_reg     <= 1'b0;
            guess_reg     <= GUESS_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            if (config_we)
            begin
                guess_reg <= config_data;
            end
            if (in_accept)
            begin
                have_prev_reg <= 1'b1;
                first_reg     <= !have_prev_reg;
            end
            // Drop a taken word, load a new one at the pick step
            if ((state_reg == S_DONE) && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Hold the previous timestamp
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            prev_time_reg <= trigger_time;
        end
    end

    // Pick the cell whose rank is the median rank
    always_comb
    begin
        picked = '0;
        for (int i = 0; i < WINDOW_SIZE; i++)
        begin
            picked = picked | (stat_value[i] & {DATA_W{is_median[i]}});
        end
    end

    // Advance the result into the output register
    always_ff @(posedge clk)
    begin
        if ((state_reg == S_DONE) && out_free)
        begin
            out_median_reg <= first_reg ? '0 : picked;
            out_flag_reg   <= !first_reg;
        end
    end

    assign out_valid       = out_valid_reg;
    assign median_interval = out_median_reg;
    assign median_valid    = out_flag_reg;

    // Row of cells; stored values shift toward the end, rotating copies ring
    for (genvar i = 0; i < WINDOW_SIZE; i++)
    begin : g_cell
        localparam int PREV = (i == 0) ? WINDOW_SIZE - 1 : i - 1;
        logic [DATA_W-1:0] shift_src;

        if (i == 0)
        begin : g_head
            assign shift_src = interval;
        end
        else
        begin : g_body
            assign shift_src = stat_value[PREV];
        end

        tmt_cell u_cell (
            .clk          (clk),
            .ctrl         (ctrl),
            .cell_index   (IDX_W'(i)),
            .fill_value   (guess_reg),
            .shift_in     (shift_src),
            .rot_in_value (rot_value[PREV]),
            .rot_in_tag   (rot_tag[PREV]),
            .stat_value   (stat_value[i]),
            .rot_value    (rot_value[i]),
            .rot_tag      (rot_tag[i]),
            .is_median    (is_median[i])
        );
    end

endmodule

`default_nettype wire

// ===== bench/tb.sv =====
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import tmt_pkg::*;

    localparam int CYCLE_LIMIT   = 200000;
    localparam int SETTLE_CYCLES = 25;
    localparam int MAX_PRINTS    = 40;

    typedef struct packed {
        logic [DATA_W-1:0] interval;
        logic              seen;
    } median_word_t;

    // DUT ports
    logic              clk          = 1'b0;
    logic              rst_n        = 1'b0;
    logic              config_we    = 1'b0;
    logic [DATA_W-1:0] config_data  = '0;
    logic              in_valid     = 1'b0;
    logic              in_stall;
    logic [TIME_W-1:0] trigger_time = '0;
    logic              out_valid;
    logic              out_stall    = 1'b0;
    logic [DATA_W-1:0] median_interval;
    logic              median_valid;

    // Predictor state
    logic [DATA_W-1:0] guess_value = GUESS_RESET;
    logic [DATA_W-1:0] gap_history [WINDOW_SIZE];
    int unsigned       gap_slot    = 0;
    logic [TIME_W-1:0] prev_stamp  = '0;
    logic              have_stamp  = 1'b0;

    median_word_t      expected_medians [$];
    median_word_t      head_median;

    // Stimulus state
    logic [TIME_W-1:0] last_time   = '0;
    logic [DATA_W-1:0] typical_gap = 32'd1000;
    bit                quiet       = 1'b0;
    int                stall_left  = 0;
    int                calm_left   = 0;

    // Bookkeeping
    int error_count     = 0;
    int sent_count      = 0;
    int results_seen    = 0;
    int backward_count  = 0;
    int saturated_count = 0;
    int guess_writes    = 0;
    int cycle_count     = 0;

    trigger_interval_median_tracker_unit dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .config_we       (config_we),
        .config_data     (config_data),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .trigger_time    (trigger_time),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .median_interval (median_interval),
        .median_valid    (median_valid)
    );

    initial
    begin
        forever #6 clk = ~clk;
    end

    // Upper median of the current gap window
    function automatic logic [DATA_W-1:0] window_median();
        logic [DATA_W-1:0] sorted [WINDOW_SIZE];
        logic [DATA_W-1:0] v;
        int j;
        sorted = gap_history;
        for (int i = 1; i < WINDOW_SIZE; i++)
        begin
            v = sorted[i];
            j = i;
            while (j > 0 && sorted[j-1] > v)
            begin
                sorted[j] = sorted[j-1];
                j--;
            end
            sorted[j] = v;
        end
        return sorted[MEDIAN_RANK];
    endfunction

    // Advance the tracker for one accepted timestamp and queue its median
    function automatic void predict_median(logic [TIME_W-1:0] stamp);
        median_word_t w;
        logic [DATA_W-1:0] gap;
        if (!have_stamp)
        begin
            for (int i = 0; i < WINDOW_SIZE; i++)
                gap_history[i] = guess_value;
            have_stamp = 1'b1;
            w.interval = '0;
            w.seen     = 1'b0;
        end
        else
        begin
            if (stamp < prev_stamp)
            begin
                gap = '0;
                backward_count++;
            end
            else if (stamp - prev_stamp > {32'd0, DATA_MAX})
            begin
                gap = DATA_MAX;
                saturated_count++;
            end
            else
                gap = DATA_W'(stamp - prev_stamp);
            gap_history[gap_slot] = gap;
            gap_slot = (gap_slot + 1) % WINDOW_SIZE;
            w.interval = window_median();
            w.seen     = 1'b1;
        end
        prev_stamp = stamp;
        expected_medians.insert(expected_medians.size(), w);
    endfunction

    task automatic report_mismatch(string what, logic [TIME_W-1:0] got,
                                   logic [TIME_W-1:0] want);
        error_count++;
        if (error_count <= MAX_PRINTS)
            $display("MISMATCH %s: got %0d, expected %0d (result %0d, %0t)",
                     what, got, want, results_seen, $realtime);
    endtask

    // Check every result word that leaves the block
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_medians.size() == 0)
                report_mismatch("unexpected word", median_interval, 0);
            else
            begin
                head_median = expected_medians.pop_front();
                if (median_interval !== head_median.interval)
                    report_mismatch("median_interval", median_interval,
                                    head_median.interval);
                if (median_valid !== head_median.seen)
                    report_mismatch("median_valid", median_valid, head_median.seen);
            end
            results_seen++;
        end
    end

    // Receiver back-pressure: random bursts with calm stretches in between
    always @(posedge clk)
    begin
        if (stall_left > 0)
        begin
            stall_left <= stall_left - 1;
            out_stall  <= 1'b1;
        end
        else if (calm_left > 0)
        begin
            calm_left <= calm_left - 1;
            out_stall <= 1'b0;
        end
        else if (!quiet && $urandom_range(0, 5) == 0)
        begin
            stall_left <= $urandom_range(0, 16);
            out_stall  <= 1'b1;
        end
        else
        begin
            if ($urandom_range(0, 29) == 0)
                calm_left <= $urandom_range(20, 120);
            out_stall <= 1'b0;
        end
    end

    // Abort a hung run
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("Timed out after %0d cycles", cycle_count);
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // Send one timestamp word, with an optional idle burst ahead of it
    task automatic send_trigger(logic [TIME_W-1:0] stamp);
        int gap;
        if (!quiet && $urandom_range(0, 3) == 0)
        begin
            gap = $urandom_range(1, 17);
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid     <= 1'b1;
        trigger_time <= stamp;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        predict_median(stamp);
        last_time = stamp;
        sent_count++;
    endtask

    // Hold the sender until every queued median has come back
    task automatic drain_results();
        in_valid <= 1'b0;
        while (expected_medians.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_guess(logic [DATA_W-1:0] value);
        config_data <= value;
        config_we   <= 1'b1;
        @(posedge clk);
        guess_value = value;
        config_we <= 1'b0;
        @(posedge clk);
        guess_writes++;
    endtask

    // Mostly steady spacing with jitter, plus backward, repeated and huge jumps
    function automatic logic [TIME_W-1:0] next_trigger_time();
        logic [TIME_W-1:0] stamp;
        logic [TIME_W-1:0] step;
        case ($urandom_range(0, 19))
            0:       stamp = {$urandom, $urandom};
            1:       stamp = last_time - $urandom_range(1, 5000);
            2:       stamp = last_time;
            3:       stamp = last_time + {$urandom_range(1, 255), $urandom};
            default:
            begin
                if ($urandom_range(0, 39) == 0)
                    typical_gap = $urandom_range(1, 32'd1 << $urandom_range(1, 30));
                step = typical_gap - (typical_gap >> 3)
                     + $urandom_range(0, typical_gap >> 2);
                stamp = last_time + step;
            end
        endcase
        return stamp;
    endfunction

    // Guess register: both extremes, then the value the first timestamp samples
    task automatic test_guess_register();
        write_guess('0);
        write_guess(DATA_MAX);
        write_guess($urandom_range(1, 2000000));
    endtask

    // First timestamp, zero time, exact and saturated gaps, time going backwards
    task automatic test_directed_timestamps();
        send_trigger(64'd0);
        send_trigger(64'd0);
        send_trigger(64'd1000);
        send_trigger(64'd1000 + 64'h0000_0000_FFFF_FFFF);
        send_trigger(last_time + 64'h0000_0001_0000_0000);
        send_trigger(64'd5);
        send_trigger(64'hFFFF_FFFF_FFFF_FFFF);
        send_trigger(64'd0);
        send_trigger(64'h0000_0000_FFFF_FFFF);
        send_trigger(64'h8000_0000_0000_0000);
        send_trigger(64'h7FFF_FFFF_FFFF_FFFF);
        repeat (12)
            send_trigger(last_time + $urandom_range(1, 3000));
        drain_results();
    endtask

    // Guess writes after the first timestamp must leave the median alone
    task automatic test_late_guess_writes();
        write_guess('0);
        send_trigger(last_time + $urandom_range(0, 50));
        send_trigger(last_time + $urandom_range(0, 50));
        drain_results();
        write_guess(DATA_MAX);
        write_guess($urandom);
        repeat (4)
            send_trigger(last_time + $urandom_range(0, 100000));
        drain_results();
    endtask

    task automatic test_steady_triggers(int count);
        repeat (count)
            send_trigger(next_trigger_time());
        drain_results();
        write_guess($urandom);
    endtask

    // Back-to-back words with no idling on either side
    task automatic test_full_rate(int count);
        quiet = 1'b1;
        repeat (count)
            send_trigger(next_trigger_time());
        drain_results();
    endtask

    initial
    begin
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_guess_register();
        test_directed_timestamps();
        test_late_guess_writes();
        test_steady_triggers(320);
        test_full_rate(105);

        $display("Sent %0d timestamps, checked %0d medians, %0d guess writes",
                 sent_count, results_seen, guess_writes);
        $display("Backward steps: %0d, saturated gaps: %0d, mismatches: %0d",
                 backward_count, saturated_count, error_count);
        if (error_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
